>>> rtl/core/bitmap_set_with_find_first_macros.svh
// assertion macros used by the bitmap set rtl
`ifndef BITMAP_SET_WITH_FIND_FIRST_MACROS_SVH
`define BITMAP_SET_WITH_FIND_FIRST_MACROS_SVH

// clocked check, off while reset is asserted
`define BSFF_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also holds across reset
`define BSFF_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bsff_pkg.sv
// shared types, codes and constants of the bitmap set
`default_nettype none

package bsff_pkg;

  localparam int WORD_BITS_DEF  = 32;
  localparam int MAX_VALUES_DEF = 1024;

  localparam int FUNC_W  = 3;
  localparam int INDEX_W = 10;
  localparam int SIZE_W  = 11;
  // bit base of a word; holds the largest size plus one word
  localparam int BASE_W  = 12;
  localparam int DIV_SH  = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  // operation codes
  localparam logic [FUNC_W-1:0] FN_SET       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_TOGGLE    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TEST      = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR_ALL = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SET_ALL   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_FIND      = 3'd6;
  localparam logic [FUNC_W-1:0] FN_POP       = 3'd7;

  // register index of size
  localparam logic REG_SIZE = 1'b0;

  typedef struct packed {
    logic active;    // word base lies below the effective size
    logic found;     // a visible member is in the word
    logic test_bit;  // selected bit of the raw word
  } bsff_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/bitmap_set_with_find_first.sv
// top level of the membership bitmap with find first and pop
//
// input channel: in_valid/in_ready carry one beat per operation (in_func,
// in_index). result channel: out_valid/out_ready carry one beat per input
// beat (out_hit, out_found_index, out_range_error), in input order.
// size register at byte address 0 of the apb-style port; pready is tied
// high, writes land on the access cycle. write it only while idle.
// the bitmap lives in one word-wide ram, NWORDS = MAX_VALUES / WORD_BITS
// words, rounded up. a shared word unit visits one word per cycle. an
// accepted beat passes through the div, split, rd, exam and fin states;
// out-of-range ops go from split straight to fin. find and pop stay in
// exam for each word examined; a scan that runs past the last active word
// examines one more. clear all and set all go from split to a fill state
// that writes each active word, then to fin. one operation is in flight
// at a time, in_ready is low meanwhile.
// after reset a clearing pass writes zero to every ram word, with in_ready
// low; size resets to 1024.
// a stalled receiver holds the result in the output register; the block
// still accepts and works on the next operation, then waits to hand it off.
`default_nettype none
`include "bitmap_set_with_find_first_macros.svh"

module bitmap_set_with_find_first import bsff_pkg::*; #(
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int MAX_VALUES = MAX_VALUES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // operation channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [INDEX_W-1:0] in_index,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_hit,
  output logic      [INDEX_W-1:0] out_found_index,
  output logic                    out_range_error,
  // apb-style config port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int NWORDS  = (MAX_VALUES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BPW     = $clog2(WORD_BITS);
  localparam int EFF_CAP = (MAX_VALUES > 2047) ? 2047 : MAX_VALUES;
  // reciprocal for splitting an index into word and bit
  localparam int RECIP   = (1 << DIV_SH) / WORD_BITS;

  // sequencer states
  localparam logic [2:0] ST_CLR   = 3'd0;  // post-reset ram sweep
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;  // reciprocal multiply
  localparam logic [2:0] ST_SPLIT = 3'd3;  // word, bit, range check
  localparam logic [2:0] ST_RD    = 3'd4;  // first ram read in flight
  localparam logic [2:0] ST_EXAM  = 3'd5;  // word unit looks at a word
  localparam logic [2:0] ST_FILL  = 3'd6;  // clear all / set all sweep
  localparam logic [2:0] ST_FIN   = 3'd7;  // hand result to output reg

  logic [2:0]           state_r, state_nxt;
  logic [SIZE_W-1:0]    size_r;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [FUNC_W-1:0]    func_r, func_nxt;
  logic [INDEX_W-1:0]   idx_r, idx_nxt;
  logic [INDEX_W-1:0]   q0_r, q0_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic [BPW-1:0]       bitpos_r, bitpos_nxt;
  logic                 hit_r, hit_nxt;
  logic [INDEX_W-1:0]   found_r, found_nxt;
  logic                 err_r, err_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [INDEX_W-1:0]   out_found_r, out_found_nxt;
  logic                 out_err_r, out_err_nxt;

  logic [SIZE_W-1:0]    eff;
  logic                 cfg_wr;
  logic [31:0]          r0_full;
  logic [31:0]          r_sel;
  logic [31:0]          q_sel;
  logic                 corr;
  logic                 in_range;

  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  bsff_flags_t          flags;
  logic [BPW-1:0]       alu_pos;
  logic [WORD_BITS-1:0] alu_wdata;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIZE);
  assign prdata = (paddr[2] == REG_SIZE) ? 32'(size_r) : '0;

  // effective size saturates at the bitmap capacity
  assign eff = (size_r > SIZE_W'(EFF_CAP)) ? SIZE_W'(EFF_CAP) : size_r;

  // index split: q0 may be one short, one compare and subtract fixes it
  assign r0_full  = 32'(idx_r) - 32'(q0_r) * 32'(WORD_BITS);
  assign corr     = r0_full >= 32'(WORD_BITS);
  assign r_sel    = corr ? (r0_full - 32'(WORD_BITS)) : r0_full;
  assign q_sel    = 32'(q0_r) + 32'(corr);
  assign in_range = SIZE_W'(idx_r) < eff;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_index = out_found_r;
  assign out_range_error = out_err_r;

  // while scanning, fetch the next word ahead of the one being examined
  assign ram_raddr = (state_r == ST_EXAM) ? (addr_r + AW'(1)) : addr_r;
  assign ram_wdata = (state_r == ST_CLR) ? '0 : alu_wdata;

  bsff_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bsff_word_alu #(
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .func    (func_r),
    .rd_word (ram_rdata),
    .base    (base_r),
    .eff     (eff),
    .bitpos  (bitpos_r),
    .flags   (flags),
    .pos     (alu_pos),
    .wdata   (alu_wdata)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    func_nxt      = func_r;
    idx_nxt       = idx_r;
    q0_nxt        = q0_r;
    base_nxt      = base_r;
    bitpos_nxt    = bitpos_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    err_nxt       = err_r;
    out_hit_nxt   = out_hit_r;
    out_found_nxt = out_found_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;

    case (state_r)
      ST_CLR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(NWORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          idx_nxt   = in_index;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        q0_nxt    = INDEX_W'((32'(idx_r) * 32'(RECIP)) >> DIV_SH);
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        hit_nxt   = 1'b0;
        found_nxt = '0;
        err_nxt   = 1'b0;
        case (func_r)
          FN_CLEAR_ALL, FN_SET_ALL: begin
            addr_nxt  = '0;
            base_nxt  = '0;
            state_nxt = ST_FILL;
          end
          FN_FIND: begin
            addr_nxt  = '0;
            base_nxt  = '0;
            state_nxt = ST_RD;
          end
          default: begin
            // indexed ops and pop; pop scans from bit 0 of the word
            if (!in_range) begin
              err_nxt   = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              addr_nxt   = AW'(q_sel);
              bitpos_nxt = BPW'(r_sel);
              base_nxt   = BASE_W'(32'(idx_r) - r_sel);
              state_nxt  = ST_RD;
            end
          end
        endcase
      end
      ST_RD: begin
        state_nxt = ST_EXAM;
      end
      ST_EXAM: begin
        case (func_r)
          FN_TEST: begin
            hit_nxt   = flags.test_bit;
            state_nxt = ST_FIN;
          end
          FN_FIND, FN_POP: begin
            if (!flags.active) begin
              state_nxt = ST_FIN;
            end else if (flags.found) begin
              hit_nxt   = 1'b1;
              found_nxt = INDEX_W'(base_r + BASE_W'(alu_pos));
              ram_we    = (func_r == FN_POP);
              state_nxt = ST_FIN;
            end else begin
              addr_nxt = addr_r + AW'(1);
              base_nxt = base_r + BASE_W'(WORD_BITS);
            end
          end
          default: begin
            // set, clear, toggle: read-modify-write of one word
            ram_we    = 1'b1;
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_FILL: begin
        if (flags.active) begin
          ram_we   = 1'b1;
          addr_nxt = addr_r + AW'(1);
          base_nxt = base_r + BASE_W'(WORD_BITS);
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_found_nxt = found_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
      size_r      <= SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        size_r <= pwdata[SIZE_W-1:0];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    idx_r       <= idx_nxt;
    q0_r        <= q0_nxt;
    base_r      <= base_nxt;
    bitpos_r    <= bitpos_nxt;
    hit_r       <= hit_nxt;
    found_r     <= found_nxt;
    err_r       <= err_nxt;
    out_hit_r   <= out_hit_nxt;
    out_found_r <= out_found_nxt;
    out_err_r   <= out_err_nxt;
  end

  // one operation in flight at a time
  `BSFF_ASSERT_CLK(a_one_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready, "second beat accepted while busy")
  // an out-of-range beat reports nothing found
  `BSFF_ASSERT_CLK(a_err_no_hit, clk, rst_n, out_valid && out_range_error |-> !out_hit && out_found_index == '0, "range error with a hit")
  // a reported member lies below the effective size
  `BSFF_ASSERT_CLK(a_found_below, clk, rst_n, out_valid && out_hit |-> SIZE_W'(out_found_index) < eff, "found index at or above size")
  // nothing moves on either channel during the clearing pass
  `BSFF_ASSERT_CLK(a_sweep_closed, clk, rst_n, state_r == ST_CLR |-> !in_ready && !out_valid, "channel open during clearing pass")
  // reset starts the clearing pass with no result pending
  `BSFF_ASSERT_ANY(a_reset_state, clk, !rst_n |=> !out_valid && state_r == ST_CLR, "reset did not start clearing pass")

endmodule

`default_nettype wire

>>> rtl/core/bsff_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module bsff_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/bsff_word_alu.sv
// shared word unit: visible mask, lowest member, bit update
`default_nettype none

module bsff_word_alu import bsff_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int BPW = $clog2(WORD_BITS)
) (
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [WORD_BITS-1:0] rd_word,
  input  wire logic [BASE_W-1:0]    base,
  input  wire logic [SIZE_W-1:0]    eff,
  input  wire logic [BPW-1:0]       bitpos,
  output bsff_flags_t               flags,
  output logic      [BPW-1:0]       pos,
  output logic      [WORD_BITS-1:0] wdata
);

  logic [BASE_W-1:0]    eff_ext;
  logic [BASE_W-1:0]    lim;
  logic                 active;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] vis;
  logic [WORD_BITS-1:0] low1;
  logic [WORD_BITS-1:0] sel_bit;

  assign eff_ext = BASE_W'(eff);
  assign active  = base < eff_ext;
  assign lim     = eff_ext - base;

  // bits of this word below the effective size
  always_comb begin
    if (!active) begin
      mask = '0;
    end else if (lim >= BASE_W'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_BITS{1'b1}} << lim[BPW-1:0]);
    end
  end

  assign vis     = rd_word & mask;
  // isolate lowest set bit
  assign low1    = vis & (~vis + WORD_BITS'(1));
  assign sel_bit = WORD_BITS'(1) << bitpos;

  always_comb begin
    pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low1[j]) begin
        pos = pos | BPW'(j);
      end
    end
  end

  assign flags.active   = active;
  assign flags.found    = |vis;
  assign flags.test_bit = |(rd_word & sel_bit);

  always_comb begin
    case (func)
      FN_SET:       wdata = rd_word | sel_bit;
      FN_CLEAR:     wdata = rd_word & ~sel_bit;
      FN_TOGGLE:    wdata = rd_word ^ sel_bit;
      FN_CLEAR_ALL: wdata = '0;
      FN_SET_ALL:   wdata = mask;
      FN_POP:       wdata = rd_word & ~low1;
      default:      wdata = rd_word;
    endcase
  end

endmodule

`default_nettype wire

>>> test/bitmap_set_with_find_first_tb.sv
// testbench for the membership bitmap with find first and pop
`timescale 1ns / 1ps

module bitmap_set_with_find_first_tb;
  import bsff_pkg::*;

  localparam int WB           = WORD_BITS_DEF;
  localparam int NUM_WORDS    = MAX_VALUES_DEF / WORD_BITS_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  // settle time before a register write and at the end of each test
  localparam int QUIET_CYCLES = 64;
  localparam logic [2:0] SIZE_ADDR = {REG_SIZE, 2'b00};

  typedef logic [WB-1:0] word_t;

  // one result beat as the block should produce it
  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] found_index;
    logic               range_error;
  } op_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [FUNC_W-1:0]  in_func;
  logic [INDEX_W-1:0] in_index;
  logic               out_valid;
  logic               out_ready;
  logic               out_hit;
  logic [INDEX_W-1:0] out_found_index;
  logic               out_range_error;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // shadow copy of the bitmap and the size register
  word_t             member_words [NUM_WORDS];
  logic [SIZE_W-1:0] size_shadow;

  op_result_t expected_results[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  // idle rates of the sender and the receiver, in percent of cycles
  int         send_idle_pct = 0;
  int         ready_stall_pct = 0;

  bitmap_set_with_find_first dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_found_index (out_found_index),
    .out_range_error (out_range_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // bitmap predictor
  // ---------------------------------------------------------------------------

  // sizes above the bitmap capacity saturate
  function automatic int unsigned effective_size();
    return (size_shadow > MAX_VALUES_DEF) ? MAX_VALUES_DEF : int'(size_shadow);
  endfunction

  // members of word w that lie below the effective size
  function automatic word_t visible_members(int unsigned w);
    int unsigned lim;
    int unsigned base;
    word_t       full;
    lim  = effective_size();
    base = w * WB;
    full = '1;
    if (base >= lim) return '0;
    if (lim - base < WB) return member_words[w] & (full >> (WB - (lim - base)));
    return member_words[w];
  endfunction

  // lowest visible member at or after bit 0 of word first_word
  function automatic bit lowest_member_from(int unsigned first_word, output int unsigned pos);
    int unsigned active;
    word_t       v;
    active = (effective_size() + WB - 1) / WB;
    pos = 0;
    for (int unsigned w = first_word; w < active; w++) begin
      v = visible_members(w);
      if (v != '0) begin
        for (int unsigned b = 0; b < WB; b++) begin
          if (v[b]) begin
            pos = w * WB + b;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // applies one operation to the shadow bitmap and gives the result it should yield
  function automatic op_result_t apply_bitmap_op(logic [FUNC_W-1:0] func,
                                                 logic [INDEX_W-1:0] index);
    op_result_t  r;
    int unsigned eff;
    int unsigned w;
    int unsigned b;
    int unsigned active;
    int unsigned pos;
    bit          in_range;
    word_t       full;
    r        = '0;
    eff      = effective_size();
    w        = index / WB;
    b        = index % WB;
    in_range = (index < eff);
    active   = (eff + WB - 1) / WB;
    full     = '1;
    case (func)
      FN_SET, FN_CLEAR, FN_TOGGLE, FN_TEST: begin
        if (!in_range) begin
          r.range_error = 1'b1;
        end else if (func == FN_SET) begin
          member_words[w][b] = 1'b1;
        end else if (func == FN_CLEAR) begin
          member_words[w][b] = 1'b0;
        end else if (func == FN_TOGGLE) begin
          member_words[w][b] = ~member_words[w][b];
        end else begin
          r.hit = member_words[w][b];
        end
      end
      FN_CLEAR_ALL: begin
        for (int unsigned i = 0; i < active; i++) member_words[i] = '0;
      end
      FN_SET_ALL: begin
        for (int unsigned i = 0; i < active; i++) member_words[i] = full;
        // bits at or above size in the last active word stay clear
        if (active > 0 && (eff % WB) != 0)
          member_words[active-1] &= full >> (WB - (eff % WB));
      end
      FN_FIND: begin
        if (lowest_member_from(0, pos)) begin
          r.hit         = 1'b1;
          r.found_index = INDEX_W'(pos);
        end
      end
      default: begin
        // pop searches from bit 0 of the word holding the start index
        if (!in_range) begin
          r.range_error = 1'b1;
        end else if (lowest_member_from(w, pos)) begin
          member_words[pos / WB][pos % WB] = 1'b0;
          r.hit         = 1'b1;
          r.found_index = INDEX_W'(pos);
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every accepted result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    op_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result beat with no operation pending");
      end else begin
        want = expected_results.pop_front();
        if (out_hit !== want.hit)
          note_mismatch($sformatf("hit got %0b want %0b", out_hit, want.hit));
        if (out_found_index !== want.found_index)
          note_mismatch($sformatf("found_index got %0d want %0d",
                                  out_found_index, want.found_index));
        if (out_range_error !== want.range_error)
          note_mismatch($sformatf("range_error got %0b want %0b",
                                  out_range_error, want.range_error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers; each one starts and ends right after a rising edge
  // ---------------------------------------------------------------------------

  // drives one operation beat and predicts its result once it is taken
  task automatic send_op(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] index);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_index <= index;
    do @(posedge clk); while (!in_ready);
    // valid stays high here; the next send or wait_idle decides what follows
    expected_results.push_back(apply_bitmap_op(func, index));
  endtask

  // stop sending and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // writes the size register while idle, then reads it back
  task automatic write_size(logic [SIZE_W-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_shadow = value;
    // read setup, then access
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SIZE_W-1:0] !== value)
      note_mismatch($sformatf("size readback got %0d want %0d",
                              prdata[SIZE_W-1:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // single-element operations at both ends of the full range
  task automatic test_single_elements();
    send_op(FN_SET, 10'd0);
    send_op(FN_SET, 10'd1023);
    send_op(FN_TEST, 10'd1023);
    send_op(FN_TEST, 10'd5);       // absent element
    send_op(FN_TOGGLE, 10'd5);
    send_op(FN_TEST, 10'd5);
    send_op(FN_CLEAR, 10'd0);
    send_op(FN_FIND, 10'd0);       // lowest is 5
    send_op(FN_POP, 10'd1023);     // search starts in the last word
    send_op(FN_POP, 10'd0);
    send_op(FN_POP, 10'd0);        // empty set, nothing found
    wait_idle();
  endtask

  // bulk fill and clear, then find and pop over a full set
  task automatic test_bulk_ops();
    send_op(FN_SET_ALL, 10'd0);
    send_op(FN_POP, 10'd40);       // from word 1, gives 32
    send_op(FN_TEST, 10'd32);
    send_op(FN_CLEAR_ALL, 10'd0);
    send_op(FN_FIND, 10'd0);
    wait_idle();
  endtask

  // size extremes, saturation, masked set all, stale bits and pop start
  task automatic test_size_limits();
    // zero size: every indexed op is out of range
    write_size(SIZE_W'(0));
    send_op(FN_SET, 10'd3);
    send_op(FN_POP, 10'd0);
    // one element
    write_size(SIZE_W'(1));
    send_op(FN_SET_ALL, 10'd0);
    send_op(FN_TEST, 10'd1);
    // above capacity saturates at full size
    write_size(SIZE_W'(2047));
    send_op(FN_SET, 10'd1023);
    // set all masks the tail of the last active word
    write_size(SIZE_W'(37));
    send_op(FN_SET_ALL, 10'd0);
    send_op(FN_TEST, 10'd37);
    write_size(SIZE_RESET);
    send_op(FN_TEST, 10'd37);
    send_op(FN_SET, 10'd1000);
    // bits above the size stay stored but are never found
    write_size(SIZE_W'(40));
    send_op(FN_CLEAR_ALL, 10'd0);
    send_op(FN_FIND, 10'd0);
    send_op(FN_SET, 10'd33);
    send_op(FN_POP, 10'd39);       // starts at bit 0 of word 1, finds 33
    write_size(SIZE_RESET);
    send_op(FN_FIND, 10'd0);       // stale 1000 visible again
    wait_idle();
  endtask

  // random operations over a few sizes at the given idle rates
  task automatic test_random_ops(int idle_pct, int stall_pct, int n_items);
    logic [SIZE_W-1:0]  sz;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
    int unsigned        eff;
    int                 pick;
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0:       sz = SIZE_RESET;
        1:       sz = SIZE_W'($urandom_range(1, MAX_VALUES_DEF));
        2:       sz = SIZE_W'($urandom_range(1, 3 * WB));   // few words, dense set
        default: sz = ($urandom_range(3) == 0) ? SIZE_W'(0)
                                               : SIZE_W'($urandom_range(1025, 2047));
      endcase
      write_size(sz);
      eff = effective_size();
      for (int k = 0; k < n_items / 4; k++) begin
        pick = $urandom_range(99);
        if (pick < 30)      func = FN_SET;
        else if (pick < 42) func = FN_CLEAR;
        else if (pick < 52) func = FN_TOGGLE;
        else if (pick < 68) func = FN_TEST;
        else if (pick < 71) func = FN_CLEAR_ALL;
        else if (pick < 74) func = FN_SET_ALL;
        else if (pick < 84) func = FN_FIND;
        else                func = FN_POP;
        // mostly in range, some anywhere in the field
        if (eff > 0 && $urandom_range(9) < 8) index = INDEX_W'($urandom_range(eff - 1));
        else                                  index = INDEX_W'($urandom_range(1023));
        send_op(func, index);
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FN_SET;
    in_index  = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    for (int i = 0; i < NUM_WORDS; i++) member_words[i] = '0;
    size_shadow = SIZE_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // the block clears its ram after reset; send_op just waits for in_ready

    test_single_elements();
    test_bulk_ops();
    test_size_limits();
    test_random_ops(0, 0, 412);
    test_random_ops(72, 0, 412);
    test_random_ops(0, 72, 412);
    test_random_ops(22, 22, 412);

    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
